// ----- rtl/emglc_pkg.sv -----
// ----------------------------------------------------------------------------
// emglc_pkg
// Shared constants and types for the EMG level calibrate-and-map block.
// ----------------------------------------------------------------------------
package emglc_pkg;

  // Default sample width
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAX_END = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLEX_END  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN  = 2'd3;

  // Register reset values
  localparam logic [8:0] ALPHA_RST     = 9'd51;
  localparam logic [7:0] RELAX_END_RST = 8'd90;
  localparam logic [7:0] FLEX_END_RST  = 8'd181;
  localparam logic [9:0] MIN_SPAN_RST  = 10'd150;

  // Filter coefficient of one (follow the sample at once)
  localparam logic [8:0] ALPHA_ONE = 9'd256;
  localparam int unsigned ALPHA_W  = 9;

  // Calibration phase codes
  localparam logic [1:0] PH_UNCAL = 2'd0;
  localparam logic [1:0] PH_RELAX = 2'd1;
  localparam logic [1:0] PH_FLEX  = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [7:0] TICK_LAST = 8'd255;

  // Position mapping
  localparam int unsigned POS_W   = 7;
  localparam logic [6:0]  POS_MAX = 7'd100;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_FILT = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_SPAN = 8'b0001_0000,
    S_MAP  = 8'b0010_0000,
    S_PDIV = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_e;

endpackage

// ----- rtl/emg_level_calibrate_and_map.sv -----
// ----------------------------------------------------------------------------
// emg_level_calibrate_and_map
// EMA envelope filter with relax-mean/flex-peak calibration and 0..100 mapping.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake                | payload (lowest bit first)
//  ---------+-----+--------------------------+----------------------------------
//  s_axis   | in  | s_axis_tvalid/tready     | tdata: sample; tuser: op
//  m_axis   | out | m_axis_tvalid/tready     | tdata: filtered_level, position,
//           |     |                          |   phase, floor_level, ceiling_level
//  cfg      | in  | cfg_we_i (no wait)       | cfg_idx_i, cfg_wdata_i
//
//  One sample at a time. A transfer is followed by a 9-step bit-serial
//  multiply by alpha, a filter/calibration step, a mapping setup step, an
//  optional 7-step restoring divide for the position and a load into the
//  output register. The tick that closes a calibration adds a SAMPLE_BITS+8
//  step restoring divide for the floor plus a span step. The output register
//  holds a result while the next sample is taken and worked on; only the
//  final load waits on m_axis_tready.
//  Reset is asynchronous and needs no clearing pass.
//
module emg_level_calibrate_and_map
  import emglc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // tdata: [SAMPLE_BITS-1:0] sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // tuser: [0] op (start calibration)
  input  logic                                   s_axis_tuser,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: filtered_level, position(7), phase(2), floor_level, ceiling_level
  output logic [((3*SAMPLE_BITS+10+7)/8)*8-1:0]  m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic                                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]                  cfg_wdata_i
);

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned ACC_W  = SB + 8;           // Q(SB).8 filter value
  localparam int unsigned PROD_W = ACC_W + 10;       // alpha * diff
  localparam int unsigned SUM_W  = SB + 16;          // baseline sum
  localparam int unsigned DIVN_W = SB + 8;           // floor dividend bits
  localparam int unsigned NUM_W  = SB + 7;           // (level-floor)*100
  localparam int unsigned WIDE_W = SB + 11;          // floor + span
  localparam int unsigned CNT_W  = $clog2(DIVN_W);
  localparam int unsigned OUT_W  = 3 * SB + 10;
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8;

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(128);

  // Configuration registers
  logic [8:0] alpha_q;
  logic [7:0] relax_end_q;
  logic [7:0] flex_end_q;
  logic [9:0] min_span_q;

  // Calibration state
  state_e          state_q, state_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [1:0]      phase_q, phase_d;
  logic [7:0]      tick_q, tick_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [7:0]      bcnt_q, bcnt_d;
  logic [SB-1:0]   floor_q, floor_d;
  logic [SB:0]     ceil_q, ceil_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Datapath working registers
  logic              op_q, op_d;
  logic signed [ACC_W:0]    diff_q, diff_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [ALPHA_W-1:0] aq_q, aq_d;
  logic [DIVN_W-1:0] dvd_q, dvd_d;
  logic [7:0]        rem_q, rem_d;
  logic [SB:0]       prem_q, prem_d;
  logic [POS_W-1:0]  pnum_q, pnum_d;
  logic [SB:0]       den_q, den_d;
  logic [SB-1:0]     level_q, level_d;
  logic [POS_W-1:0]  pos_q, pos_d;

  // Output register
  logic              mval_q, mval_d;
  logic [SB-1:0]     o_level_q, o_level_d;
  logic [POS_W-1:0]  o_pos_q, o_pos_d;
  logic [1:0]        o_phase_q, o_phase_d;
  logic [SB-1:0]     o_floor_q, o_floor_d;
  logic [SB:0]       o_ceil_q, o_ceil_d;

  // Combinational helpers
  logic [ALPHA_W-1:0]       a_cap;
  logic signed [PROD_W-1:0] prod_rnd, prod_inc, nacc;
  logic [ACC_W-1:0]         acc_new;
  logic [ACC_W:0]           lvl_rnd;
  logic [SB-1:0]            level_new;
  logic                     start;
  logic [7:0]               tick_e, bcnt_e;
  logic [SUM_W-1:0]         sum_e;
  logic [SB:0]              ceil_e;
  logic [1:0]               phase_e;
  logic [8:0]               div_r;
  logic                     div_qb;
  logic [DIVN_W-1:0]        div_quo;
  logic [9:0]               span;
  logic [WIDE_W-1:0]        fs_sum;
  logic [SB-1:0]            map_d;
  logic [SB:0]              map_den;
  logic [NUM_W-1:0]         map_num;
  logic [SB+1:0]            pdiv_r;
  logic                     pdiv_qb;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = OUT_TW'({o_ceil_q, o_floor_q, o_phase_q, o_pos_q, o_level_q});

  // Filter arithmetic: round half up, floor on the arithmetic shift
  assign a_cap    = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign prod_rnd = prod_q + RND_HALF;
  assign prod_inc = prod_rnd >>> 8;
  assign nacc     = $signed({{(PROD_W-ACC_W){1'b0}}, acc_q}) + prod_inc;
  assign acc_new  = nacc[PROD_W-1] ? '0 : nacc[ACC_W-1:0];
  assign lvl_rnd  = {1'b0, acc_new} + (ACC_W+1)'(128);
  assign level_new = lvl_rnd[ACC_W] ? '1 : lvl_rnd[ACC_W-1:8];

  // A start restarts calibration from a clean slate on this very tick
  assign start   = op_q && ((phase_q == PH_UNCAL) || (phase_q == PH_DONE));
  assign tick_e  = start ? '0 : tick_q;
  assign bcnt_e  = start ? '0 : bcnt_q;
  assign sum_e   = start ? '0 : sum_q;
  assign ceil_e  = start ? '0 : ceil_q;
  assign phase_e = start ? PH_RELAX : phase_q;

  // Floor divider step: baseline_sum/256 over count, one quotient bit a cycle
  assign div_r   = {rem_q, dvd_q[DIVN_W-1]};
  assign div_qb  = (div_r >= {1'b0, bcnt_q});
  assign div_quo = {dvd_q[DIVN_W-2:0], div_qb};

  // Span enforcement
  assign span   = (min_span_q == '0) ? 10'd1 : min_span_q;
  assign fs_sum = WIDE_W'(floor_q) + WIDE_W'(span);

  // Mapping setup
  assign map_d   = level_q - floor_q;
  assign map_den = (ceil_q > {1'b0, floor_q}) ? (ceil_q - {1'b0, floor_q}) : (SB+1)'(1);
  assign map_num = NUM_W'({map_d, 6'b0}) + NUM_W'({map_d, 5'b0}) + NUM_W'({map_d, 2'b0});

  // Position divider step
  assign pdiv_r  = {prem_q, pnum_q[POS_W-1]};
  assign pdiv_qb = (pdiv_r >= {1'b0, den_q});

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    phase_d   = phase_q;
    tick_d    = tick_q;
    sum_d     = sum_q;
    bcnt_d    = bcnt_q;
    floor_d   = floor_q;
    ceil_d    = ceil_q;
    cnt_d     = cnt_q;
    op_d      = op_q;
    diff_d    = diff_q;
    prod_d    = prod_q;
    aq_d      = aq_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    prem_d    = prem_q;
    pnum_d    = pnum_q;
    den_d     = den_q;
    level_d   = level_q;
    pos_d     = pos_q;
    mval_d    = mval_q;
    o_level_d = o_level_q;
    o_pos_d   = o_pos_q;
    o_phase_d = o_phase_q;
    o_floor_d = o_floor_q;
    o_ceil_d  = o_ceil_q;

    // Drop the result once the sink takes it
    if (mval_q && m_axis_tready) begin
      mval_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = s_axis_tuser;
          diff_d  = $signed({1'b0, s_axis_tdata[SB-1:0], 8'b0}) - $signed({1'b0, acc_q});
          prod_d  = '0;
          aq_d    = a_cap;
          cnt_d   = CNT_W'(ALPHA_W - 1);
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // MSB-first shift and add over the alpha bits
        prod_d = (prod_q <<< 1) + (aq_q[ALPHA_W-1] ? {{9{diff_q[ACC_W]}}, diff_q} : '0);
        aq_d   = {aq_q[ALPHA_W-2:0], 1'b0};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_FILT;
        end
      end
      S_FILT: begin
        acc_d   = acc_new;
        level_d = level_new;
        tick_d  = tick_e;
        bcnt_d  = bcnt_e;
        sum_d   = sum_e;
        ceil_d  = ceil_e;
        phase_d = phase_e;
        if (start) begin
          floor_d = '1;
        end
        state_d = S_MAP;
        if ((phase_e == PH_RELAX) || (phase_e == PH_FLEX)) begin
          priority if ((tick_e <= relax_end_q) && (tick_e != TICK_LAST)) begin
            sum_d   = sum_e + SUM_W'(acc_new);
            bcnt_d  = bcnt_e + 1'b1;
            phase_d = PH_RELAX;
            tick_d  = tick_e + 1'b1;
          end else if ((tick_e <= flex_end_q) && (tick_e != TICK_LAST)) begin
            if ({1'b0, level_new} > ceil_e) begin
              ceil_d = {1'b0, level_new};
            end
            phase_d = PH_FLEX;
            tick_d  = tick_e + 1'b1;
          end else begin
            // Close the calibration: derive the floor, then enforce the span
            if (bcnt_e == '0) begin
              floor_d = '0;
              state_d = S_SPAN;
            end else begin
              dvd_d   = sum_e[SUM_W-1:8];
              rem_d   = '0;
              cnt_d   = CNT_W'(DIVN_W - 1);
              state_d = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        rem_d = div_qb ? 8'(div_r - {1'b0, bcnt_q}) : div_r[7:0];
        dvd_d = div_quo;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          floor_d = (|div_quo[DIVN_W-1:SB]) ? '1 : div_quo[SB-1:0];
          state_d = S_SPAN;
        end
      end
      S_SPAN: begin
        if (WIDE_W'(ceil_q) < fs_sum) begin
          ceil_d = fs_sum[SB:0];
        end
        phase_d = PH_DONE;
        state_d = S_MAP;
      end
      S_MAP: begin
        if ((phase_q == PH_DONE) && (level_q > floor_q)) begin
          if ({1'b0, map_d} >= map_den) begin
            pos_d   = POS_MAX;
            state_d = S_EMIT;
          end else begin
            prem_d  = {1'b0, map_num[NUM_W-1:POS_W]};
            pnum_d  = map_num[POS_W-1:0];
            den_d   = map_den;
            cnt_d   = CNT_W'(POS_W - 1);
            state_d = S_PDIV;
          end
        end else begin
          pos_d   = '0;
          state_d = S_EMIT;
        end
      end
      S_PDIV: begin
        prem_d = pdiv_qb ? (SB+1)'(pdiv_r - {1'b0, den_q}) : pdiv_r[SB:0];
        pnum_d = {pnum_q[POS_W-2:0], pdiv_qb};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          pos_d   = {pnum_q[POS_W-2:0], pdiv_qb};
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // Load the output register once it is free
        if (!mval_q || m_axis_tready) begin
          mval_d    = 1'b1;
          o_level_d = level_q;
          o_pos_d   = pos_q;
          o_phase_d = phase_q;
          o_floor_d = floor_q;
          o_ceil_d  = ceil_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      phase_q     <= PH_UNCAL;
      tick_q      <= '0;
      sum_q       <= '0;
      bcnt_q      <= '0;
      floor_q     <= '1;
      ceil_q      <= '0;
      cnt_q       <= '0;
      mval_q      <= 1'b0;
      alpha_q     <= ALPHA_RST;
      relax_end_q <= RELAX_END_RST;
      flex_end_q  <= FLEX_END_RST;
      min_span_q  <= MIN_SPAN_RST;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      phase_q <= phase_d;
      tick_q  <= tick_d;
      sum_q   <= sum_d;
      bcnt_q  <= bcnt_d;
      floor_q <= floor_d;
      ceil_q  <= ceil_d;
      cnt_q   <= cnt_d;
      mval_q  <= mval_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ALPHA:     alpha_q     <= cfg_wdata_i[8:0];
          CFG_RELAX_END: relax_end_q <= cfg_wdata_i[7:0];
          CFG_FLEX_END:  flex_end_q  <= cfg_wdata_i[7:0];
          CFG_MIN_SPAN:  min_span_q  <= cfg_wdata_i[9:0];
          default:       alpha_q     <= alpha_q;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    diff_q    <= diff_d;
    prod_q    <= prod_d;
    aq_q      <= aq_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    prem_q    <= prem_d;
    pnum_q    <= pnum_d;
    den_q     <= den_d;
    level_q   <= level_d;
    pos_q     <= pos_d;
    o_level_q <= o_level_d;
    o_pos_q   <= o_pos_d;
    o_phase_q <= o_phase_d;
    o_floor_q <= o_floor_d;
    o_ceil_q  <= o_ceil_d;
  end

endmodule

// ----- tb/emg_level_calibrate_and_map_checker.sv -----
// ----------------------------------------------------------------------------
// emg_level_calibrate_and_map_checker
// Watches the sample, result and configuration channels, predicts each
// result tick by tick and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module emg_level_calibrate_and_map_checker
  import emglc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // tdata: [SAMPLE_BITS-1:0] sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // tuser: [0] op (start calibration)
  input  logic                                  s_axis_tuser,
  input  logic                                  s_axis_tvalid,
  input  logic                                  s_axis_tready,
  // tdata: filtered_level, position(7), phase(2), floor_level, ceiling_level
  input  logic [((3*SAMPLE_BITS+10+7)/8)*8-1:0] m_axis_tdata,
  input  logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic                                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]                 cfg_wdata_i,
  output int                                    fail_count_o,
  output int                                    pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SB = SAMPLE_BITS;
  localparam longint LEVEL_MAX = (longint'(1) << SB) - 1;
  localparam longint CEIL_MASK = (longint'(1) << (SB + 1)) - 1;

  typedef struct packed {
    logic [SB-1:0] level;
    logic [6:0]    position;
    logic [1:0]    phase;
    logic [SB-1:0] floor_lvl;
    logic [SB:0]   ceil_lvl;
  } tick_result_t;

  // Register copies
  longint alpha_r, relax_end_r, flex_end_r, span_r;

  // Filter and calibration state
  longint     ema_acc;
  logic [1:0] cal_phase;
  longint     tick_idx;
  longint     baseline_sum;
  longint     baseline_cnt;
  longint     floor_lvl;
  longint     ceil_lvl;

  tick_result_t expected_ticks[$];
  int           mismatch_count;
  int           report_count;
  int           result_idx;

  function automatic tick_result_t predict_tick(input logic op, input logic [SB-1:0] smp);
    longint       alpha_eff, delta, next_acc, lvl, span, den, pos;
    tick_result_t res;
    alpha_eff = (alpha_r > 256) ? 256 : alpha_r;
    delta     = (longint'(smp) <<< 8) - ema_acc;
    // round half up, floor division for negative steps
    next_acc  = ema_acc + ((alpha_eff * delta + 128) >>> 8);
    if (next_acc < 0) next_acc = 0;
    ema_acc = next_acc;
    lvl = (ema_acc + 128) >>> 8;
    if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;

    // start is honored only outside a running calibration
    if (op && (cal_phase == PH_UNCAL || cal_phase == PH_DONE)) begin
      tick_idx     = 0;
      baseline_sum = 0;
      baseline_cnt = 0;
      floor_lvl    = LEVEL_MAX;
      ceil_lvl     = 0;
      cal_phase    = PH_RELAX;
    end

    if (cal_phase == PH_RELAX || cal_phase == PH_FLEX) begin
      if (tick_idx <= relax_end_r && tick_idx < 255) begin
        baseline_sum += ema_acc;
        baseline_cnt += 1;
        cal_phase     = PH_RELAX;
        tick_idx     += 1;
      end else if (tick_idx <= flex_end_r && tick_idx < 255) begin
        if (lvl > ceil_lvl) ceil_lvl = lvl;
        cal_phase = PH_FLEX;
        tick_idx += 1;
      end else begin
        span      = (span_r == 0) ? 1 : span_r;
        floor_lvl = (baseline_cnt != 0) ? baseline_sum / (baseline_cnt * 256) : 0;
        if (floor_lvl > LEVEL_MAX) floor_lvl = LEVEL_MAX;
        if (ceil_lvl - floor_lvl < span) ceil_lvl = floor_lvl + span;
        ceil_lvl  = ceil_lvl & CEIL_MASK;
        cal_phase = PH_DONE;
      end
    end

    pos = 0;
    if (cal_phase == PH_DONE && lvl > floor_lvl) begin
      den = (ceil_lvl > floor_lvl) ? ceil_lvl - floor_lvl : 1;
      pos = (lvl - floor_lvl) * 100 / den;
      if (pos > 100) pos = 100;
    end

    res.level     = lvl[SB-1:0];
    res.position  = pos[6:0];
    res.phase     = cal_phase;
    res.floor_lvl = floor_lvl[SB-1:0];
    res.ceil_lvl  = ceil_lvl[SB:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t got, want;
    if (!rst_ni) begin
      alpha_r      = ALPHA_RST;
      relax_end_r  = RELAX_END_RST;
      flex_end_r   = FLEX_END_RST;
      span_r       = MIN_SPAN_RST;
      ema_acc      = 0;
      cal_phase    = PH_UNCAL;
      tick_idx     = 0;
      baseline_sum = 0;
      baseline_cnt = 0;
      floor_lvl    = LEVEL_MAX;
      ceil_lvl     = 0;
      expected_ticks.delete();
      mismatch_count = 0;
      report_count   = 0;
      result_idx     = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // retire a result first: it never belongs to a sample taken on this edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.level     = m_axis_tdata[SB-1:0];
        got.position  = m_axis_tdata[SB+6:SB];
        got.phase     = m_axis_tdata[SB+8:SB+7];
        got.floor_lvl = m_axis_tdata[2*SB+8:SB+9];
        got.ceil_lvl  = m_axis_tdata[3*SB+9:2*SB+9];
        if (expected_ticks.size() == 0) begin
          mismatch_count++;
          if (report_count < 10) begin
            report_count++;
            $display("%0t: result %0d arrived with nothing pending", $realtime, result_idx);
          end
        end else begin
          want = expected_ticks.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (report_count < 10) begin
              report_count++;
              $display("%0t: result %0d level/pos/phase/floor/ceil exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                       $realtime, result_idx, want.level, want.position, want.phase,
                       want.floor_lvl, want.ceil_lvl, got.level, got.position, got.phase,
                       got.floor_lvl, got.ceil_lvl);
            end
          end
        end
        result_idx++;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ALPHA:     alpha_r     = cfg_wdata_i[ALPHA_W-1:0];
          CFG_RELAX_END: relax_end_r = cfg_wdata_i[7:0];
          CFG_FLEX_END:  flex_end_r  = cfg_wdata_i[7:0];
          CFG_MIN_SPAN:  span_r      = cfg_wdata_i[9:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready)
        expected_ticks.push_back(predict_tick(s_axis_tuser, s_axis_tdata[SB-1:0]));

      pending_o    <= expected_ticks.size();
      fail_count_o <= mismatch_count;
    end
  end

endmodule

// ----- tb/emg_level_calibrate_and_map_tb.sv -----
// ----------------------------------------------------------------------------
// emg_level_calibrate_and_map_tb
// Drives envelope samples and calibration starts through the block under
// several register settings and random backpressure; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module emg_level_calibrate_and_map_tb;
  import emglc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SB       = SAMPLE_BITS_DEF;
  localparam int unsigned S_DATA_W = ((SB + 7) / 8) * 8;
  localparam int unsigned M_DATA_W = ((3 * SB + 10 + 7) / 8) * 8;

  // Directed ticks as {op, sample}: extremes while uncalibrated, a full
  // calibration with ignored restarts, mapping below floor and at the ceiling,
  // a restart once calibrated, then a flat run that forces the span widening.
  localparam logic [12:0] DIRECTED_TICKS [25] = '{
    {1'b0, 12'd0},    {1'b0, 12'd4095}, {1'b0, 12'h555},  {1'b0, 12'hAAA},
    {1'b1, 12'd100},  {1'b0, 12'd110},  {1'b1, 12'd120},  {1'b0, 12'd130},
    {1'b0, 12'd3000}, {1'b0, 12'd4095}, {1'b1, 12'd2000}, {1'b0, 12'd500},
    {1'b0, 12'd0},    {1'b0, 12'd4095}, {1'b0, 12'd2000},
    {1'b1, 12'd50},   {1'b0, 12'd50},   {1'b0, 12'd50},   {1'b0, 12'd50},
    {1'b0, 12'd60},   {1'b0, 12'd60},   {1'b0, 12'd60},   {1'b0, 12'd60},
    {1'b0, 12'd120},  {1'b0, 12'd4095}
  };

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = CFG_ALPHA;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  int check_failures;
  int ticks_pending;

  // Percent of cycles in which each side idles
  int tx_idle_pct = 38;
  int rx_idle_pct = 70;

  emg_level_calibrate_and_map u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  emg_level_calibrate_and_map_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (check_failures),
    .pending_o     (ticks_pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off after the 150th
  // transfer so the output register and the input both back up.
  initial begin
    int results_seen;
    int hold_left;
    bit hold_done;
    results_seen = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) results_seen++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (results_seen == 150 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 500;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offer one tick and hold it until the block takes it; random gaps drop
  // valid beforehand, otherwise valid stays high from the previous transfer.
  task automatic push_sample(input logic op, input logic [SB-1:0] smp);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= S_DATA_W'(smp);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every predicted result has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (ticks_pending != 0);
  endtask

  // Write all four registers on consecutive edges while the block is idle.
  task automatic write_regs(input logic [9:0] alpha, input logic [9:0] relax_end,
                            input logic [9:0] flex_end, input logic [9:0] span);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ALPHA;
    cfg_wdata_i <= alpha;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_RELAX_END;
    cfg_wdata_i <= relax_end;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_FLEX_END;
    cfg_wdata_i <= flex_end;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MIN_SPAN;
    cfg_wdata_i <= span;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // One setting: open with a start, then mostly quiet samples while the
  // baseline is averaged, strong ones during peak capture and anything in
  // between once calibrated; a slice of full-range noise and stray starts.
  task automatic run_phase(input logic [9:0] alpha, input logic [9:0] relax_end,
                           input logic [9:0] flex_end, input logic [9:0] span,
                           input int n_ticks);
    int          since_start;
    int          lo_base;
    int          hi_base;
    int          kind;
    logic        op;
    logic [SB-1:0] smp;
    write_regs(alpha, relax_end, flex_end, span);
    lo_base     = $urandom_range(0, 1500);
    hi_base     = $urandom_range(lo_base + 200, 4032);
    since_start = 0;
    for (int i = 0; i < n_ticks; i++) begin
      op = (i == 0) || ($urandom_range(0, 59) == 0);
      if (op) since_start = 0;
      kind = $urandom_range(0, 9);
      if (kind == 0)
        smp = SB'($urandom_range(0, 4095));
      else if (since_start <= relax_end)
        smp = SB'(lo_base + $urandom_range(0, 63));
      else if (since_start <= flex_end)
        smp = SB'(hi_base + $urandom_range(0, 63));
      else
        smp = SB'($urandom_range(lo_base, hi_base + 63));
      push_sample(op, smp);
      since_start++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: instant filter, short relax and flex parts
    write_regs(10'd256, 10'd3, 10'd6, 10'd150);
    foreach (DIRECTED_TICKS[i]) push_sample(DIRECTED_TICKS[i][12], DIRECTED_TICKS[i][11:0]);

    // Reset values, then the low extremes
    run_phase(10'(ALPHA_RST), 10'(RELAX_END_RST), 10'(FLEX_END_RST), 10'(MIN_SPAN_RST), 220);
    run_phase(10'd1, 10'd0, 10'd1, 10'd1, 100);
    run_phase(10'($urandom_range(1, 256)), 10'($urandom_range(0, 20)),
              10'($urandom_range(0, 50)), 10'($urandom_range(0, 1023)), 60);

    // Swap the idle pattern between the two sides
    tx_idle_pct = 70;
    rx_idle_pct = 38;
    // Alpha above one, relax until the index ceiling, flex skipped, widest span
    run_phase(10'd511, 10'd255, 10'd255, 10'd1023, 300);
    // Frozen filter, flex end below relax end, span of zero
    run_phase(10'd0, 10'd5, 10'd2, 10'd0, 80);
    run_phase(10'($urandom_range(1, 256)), 10'($urandom_range(0, 20)),
              10'($urandom_range(0, 50)), 10'($urandom_range(0, 1023)), 60);

    // Full rate on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(10'($urandom_range(1, 256)), 10'($urandom_range(0, 20)),
              10'($urandom_range(0, 50)), 10'($urandom_range(0, 1023)), 60);
    run_phase(10'd300, 10'd10, 10'd40, 10'd512, 120);

    drain_results();
    repeat (60) @(posedge clk_i);
    if (check_failures == 0) begin
      $display("emg_level_calibrate_and_map verification clean");
    end else begin
      $display("emg_level_calibrate_and_map verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("emg_level_calibrate_and_map verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/emglc_pkg.sv
rtl/emg_level_calibrate_and_map.sv
tb/emg_level_calibrate_and_map_checker.sv
tb/emg_level_calibrate_and_map_tb.sv
